// ===== rtl/pcts_pkg.sv =====
package pcts_pkg;

  // Sizes of the trigger table, the fixed-point phase and the line, tick and index fields.
  localparam int NUM_TRIGGERS = 16;
  localparam int PHASE_BITS   = 24;
  localparam int NUM_LINES    = 16;
  localparam int SLOT_W       = $clog2(NUM_TRIGGERS);
  localparam int LINE_W       = $clog2(NUM_LINES);
  localparam int TICK_W       = 32;
  localparam int REG_IDX_W    = 1;

  // Command codes carried in the action field.
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_RESET = 2'd2
  } action_t;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PHASE_STEP  = 1'b0,
    REG_TRACK_MUTED = 1'b1
  } reg_idx_t;

  // Scanner states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } scan_state_t;

  // One command beat.
  typedef struct packed {
    logic [1:0]            action;
    logic [SLOT_W-1:0]     slot;
    logic [PHASE_BITS-1:0] slot_phase;
    logic [LINE_W-1:0]     slot_line;
    logic                  slot_valid;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [LINE_W-1:0]     fired_line;
    logic [PHASE_BITS-1:0] fired_phase;
    logic [TICK_W-1:0]     event_tick;
    logic                  last;
  } result_t;

  // One entry of the trigger memory.
  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [LINE_W-1:0]     line;
  } trig_entry_t;

  // Scan request from the transport logic to the scanner.
  typedef struct packed {
    logic                  go;
    logic [PHASE_BITS-1:0] from_phase;
    logic [PHASE_BITS-1:0] to_phase;
  } scan_req_t;

endpackage

// ===== rtl/phase_crossing_trigger_sequencer.sv =====
// Channel   Ports                                     Handshake
// command   start, busy, cmd                          beat taken when start && !busy
// config    cfg_valid, cfg_ready, cfg_index, cfg_data write when cfg_valid && cfg_ready
// result    result_valid, result                      one-cycle strobe, always taken
//
// Load, reset and muted tick commands do not raise busy.
// An unmuted tick holds busy through the scan: the trigger memory is read one slot a cycle,
// then a drain state takes the last read and a flush state sends the final event.
// Events leave in slot order, each in the cycle after the next crossing or the flush.
// Synchronous reset clears phase, tick count, slot enables, registers and the scanner.
// The receiver cannot stall; cfg_ready is always high.
module phase_crossing_trigger_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  pcts_pkg::cmd_t                      cmd,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcts_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [pcts_pkg::PHASE_BITS-1:0]     cfg_data,
  output pcts_pkg::result_t                   result,
  output logic                                result_valid
);

  logic [pcts_pkg::PHASE_BITS-1:0]   phase_step;
  logic                              track_muted;
  logic [pcts_pkg::PHASE_BITS-1:0]   loop_phase;
  logic [pcts_pkg::PHASE_BITS-1:0]   loop_phase_next;
  logic [pcts_pkg::TICK_W-1:0]       tick_count;
  logic [pcts_pkg::NUM_TRIGGERS-1:0] slot_enabled;
  logic                              accept;
  logic                              is_load;
  logic                              is_tick;
  logic                              is_reset;
  pcts_pkg::scan_req_t               req;
  pcts_pkg::trig_entry_t             wr_data;
  pcts_pkg::trig_entry_t             rd_data;
  logic [pcts_pkg::SLOT_W-1:0]       rd_addr;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Command decode; the unused code does nothing.
  always_comb begin
    is_load  = 1'b0;
    is_tick  = 1'b0;
    is_reset = 1'b0;
    unique case (cmd.action)
      pcts_pkg::ACT_LOAD:  is_load  = accept;
      pcts_pkg::ACT_TICK:  is_tick  = accept;
      pcts_pkg::ACT_RESET: is_reset = accept;
      default: ;
    endcase
  end

  // Phase advances modulo one loop.
  assign loop_phase_next = loop_phase + phase_step;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= '0;
      track_muted <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcts_pkg::REG_PHASE_STEP:  phase_step  <= cfg_data;
        pcts_pkg::REG_TRACK_MUTED: track_muted <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Transport: phase and tick counter.
  always_ff @(posedge clk) begin
    if (rst || is_reset) begin
      loop_phase <= '0;
      tick_count <= '0;
    end else if (is_tick) begin
      loop_phase <= loop_phase_next;
      tick_count <= tick_count + pcts_pkg::TICK_W'(1);
    end
  end

  // Slot enable bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_enabled <= '0;
    end else if (is_load) begin
      slot_enabled[cmd.slot] <= cmd.slot_valid;
    end
  end

  // Scan request for an unmuted tick.
  always_comb begin
    req.go         = is_tick && !track_muted;
    req.from_phase = loop_phase;
    req.to_phase   = loop_phase_next;
  end

  assign wr_data.phase = cmd.slot_phase;
  assign wr_data.line  = cmd.slot_line;

  pcts_trig_mem u_mem (
    .clk     (clk),
    .wr_en   (is_load),
    .wr_addr (cmd.slot),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pcts_scanner u_scan (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .enabled      (slot_enabled),
    .tick_count   (tick_count),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ===== rtl/pcts_trig_mem.sv =====
module pcts_trig_mem (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [pcts_pkg::SLOT_W-1:0]         wr_addr,
  input  pcts_pkg::trig_entry_t               wr_data,
  input  logic [pcts_pkg::SLOT_W-1:0]         rd_addr,
  output pcts_pkg::trig_entry_t               rd_data
);

  pcts_pkg::trig_entry_t mem [pcts_pkg::NUM_TRIGGERS];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/pcts_scanner.sv =====
module pcts_scanner (
  input  logic                                clk,
  input  logic                                rst,
  input  pcts_pkg::scan_req_t                 req,
  input  logic [pcts_pkg::NUM_TRIGGERS-1:0]   enabled,
  input  logic [pcts_pkg::TICK_W-1:0]         tick_count,
  output logic [pcts_pkg::SLOT_W-1:0]         rd_addr,
  input  pcts_pkg::trig_entry_t               rd_data,
  output logic                                busy,
  output pcts_pkg::result_t                   result,
  output logic                                result_valid
);

  pcts_pkg::scan_state_t state, state_next;

  logic [pcts_pkg::SLOT_W-1:0]     idx;
  logic                            rd_vld;
  logic [pcts_pkg::PHASE_BITS-1:0] scan_from;
  logic [pcts_pkg::PHASE_BITS-1:0] scan_to;
  logic                            scan_wrap;
  pcts_pkg::trig_entry_t           pend;
  logic                            pend_vld;
  logic                            hit;
  logic                            emit;
  pcts_pkg::result_t               emit_data;
  logic                            at_end;

  assign rd_addr = idx;
  assign busy    = (state != pcts_pkg::ST_IDLE);
  assign at_end  = (idx == pcts_pkg::SLOT_W'(pcts_pkg::NUM_TRIGGERS - 1));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: one read per cycle in the scan, then a drain state for the last read and a flush state.
  always_comb begin
    state_next = state;
    unique case (state)
      pcts_pkg::ST_IDLE: begin
        if (req.go) begin
          state_next = pcts_pkg::ST_SCAN;
        end
      end
      pcts_pkg::ST_SCAN: begin
        if (at_end) begin
          state_next = pcts_pkg::ST_DRAIN;
        end
      end
      pcts_pkg::ST_DRAIN: state_next = pcts_pkg::ST_FLUSH;
      pcts_pkg::ST_FLUSH: state_next = pcts_pkg::ST_IDLE;
      default:            state_next = pcts_pkg::ST_IDLE;
    endcase
  end

  // Capture the phase window of the tick.
  always_ff @(posedge clk) begin
    if (req.go && state == pcts_pkg::ST_IDLE) begin
      scan_from <= req.from_phase;
      scan_to   <= req.to_phase;
      scan_wrap <= (req.from_phase > req.to_phase);
    end
  end

  // Slot counter and the enable bit that travels with each read.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == pcts_pkg::ST_SCAN) && enabled[idx];
      if (state == pcts_pkg::ST_SCAN) begin
        idx <= idx + pcts_pkg::SLOT_W'(1);
      end else begin
        idx <= '0;
      end
    end
  end

  // Crossing test on the entry that just came back from memory.
  always_comb begin
    if (scan_wrap) begin
      hit = rd_vld && ((rd_data.phase >= scan_from) || (rd_data.phase < scan_to));
    end else begin
      hit = rd_vld && (rd_data.phase >= scan_from) && (rd_data.phase < scan_to);
    end
  end

  // A crossing is held back one step so the final one can be marked last.
  always_comb begin
    emit_data.fired_line  = pend.line;
    emit_data.fired_phase = pend.phase;
    emit_data.event_tick  = tick_count;
    emit_data.last        = 1'b0;
    emit                  = 1'b0;
    if (state == pcts_pkg::ST_FLUSH) begin
      emit           = pend_vld;
      emit_data.last = 1'b1;
    end else if (hit) begin
      emit = pend_vld;
    end
  end

  // Held crossing.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
    end else if (hit) begin
      pend_vld <= 1'b1;
    end else if (state == pcts_pkg::ST_FLUSH) begin
      pend_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      pend <= rd_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_data;
    end
  end

  // The last beat of a tick leaves the scanner idle.
  a_last_ends_scan: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> state == pcts_pkg::ST_IDLE)
    else $error("last beat while scan still running");

  // A held crossing never survives into idle.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == pcts_pkg::ST_IDLE |-> !pend_vld)
    else $error("held crossing left in idle");

  // Read data is only checked for reads issued during the scan.
  a_read_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state == pcts_pkg::ST_SCAN))
    else $error("read data valid outside a scan");

  // A scan request never arrives while a scan runs.
  a_go_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.go |-> state == pcts_pkg::ST_IDLE)
    else $error("scan request while busy");

endmodule
